[hdl/chm_pkg.sv]
// Package with the sequencer state type of the convex hull unit.
package chm_pkg;

    // Sequencer states: loading, insertion sort, hull walk, emission.
    typedef enum logic [3:0] {
        S_LOAD,
        S_SKEY,
        S_SKEYW,
        S_SCMP,
        S_HRD,
        S_HP,
        S_HCHK,
        S_HDEC,
        S_HPOPW,
        S_ERD,
        S_ELD,
        S_EOUT
    } t_state;

endpackage

[hdl/chm_if.sv]
// Handshake interfaces for the point input and the hull vertex output.
interface chm_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface chm_out_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         hull_last;

    modport source (output valid, hull_x, hull_y, hull_last, input ready);
    modport sink (input valid, hull_x, hull_y, hull_last, output ready);
endinterface

[hdl/convex_hull_monotone_chain_unit.sv]
// Convex hull unit: point store, in-memory insertion sort and stack based hull walk.
//
//  Channel  | Dir | Payload                          | Transaction
//  i_pt     | in  | point_x, point_y, last_point     | valid & ready
//  o_hull   | out | hull_x, hull_y, hull_last        | valid & ready
//
// Points are taken one per cycle while loading; a point beyond MAX_POINTS is dropped.
// The final point starts an insertion sort in the point memory when more than one point is
// stored (one memory read per step), then the hull walk, which waits on the registered stack
// memory read and on the registered products of the cross product unit.
// Each hull vertex is read from the stack and held until accepted; no input is taken meanwhile.
// Reset is synchronous and active low; it clears the sequencer, counters and output valid only.
module convex_hull_monotone_chain_unit #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chm_in_if.sink    i_pt,
    chm_out_if.source o_hull
);
    import chm_pkg::*;

    localparam int STACK_DEPTH = 2 * MAX_POINTS;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int TOP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);
    localparam int PT_W  = 2 * COORD_BITS;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_count, r_n, r_i;
    logic [IDX_W-1:0] r_j;
    logic [TOP_W-1:0] r_top, r_floor, r_k;
    logic             r_upper;
    logic [PT_W-1:0]  r_key, r_p, r_a, r_b;
    logic             r_ov;
    logic [PT_W-1:0]  r_o;
    logic             r_olast;

    // Point memory and hull stack memory with registered read data.
    logic [PT_W-1:0] r_pmem [MAX_POINTS];
    logic [PT_W-1:0] r_pq;
    logic [PT_W-1:0] r_smem [STACK_DEPTH];
    logic [PT_W-1:0] r_sq;

    logic             pm_we, sm_we;
    logic [IDX_W-1:0] pm_wa, pm_ra;
    logic [PT_W-1:0]  pm_wd;
    logic [SA_W-1:0]  sm_wa, sm_ra;

    logic w_acc, w_store, w_before, w_shift, w_chk, w_nonpos, w_push, w_pop;
    logic w_lower_end, w_upper_end, w_oacc, w_elast;
    logic [TOP_W-1:0] w_top_dec;

    assign w_acc   = i_pt.valid & i_pt.ready;
    assign w_store = w_acc && (r_count < CNT_W'(MAX_POINTS));
    assign w_oacc  = o_hull.valid & o_hull.ready;

    // Sort order: x first, then y, both signed.
    assign w_before = ($signed(r_key[PT_W-1:COORD_BITS]) < $signed(r_pq[PT_W-1:COORD_BITS]))
        || ((r_key[PT_W-1:COORD_BITS] == r_pq[PT_W-1:COORD_BITS])
            && ($signed(r_key[COORD_BITS-1:0]) < $signed(r_pq[COORD_BITS-1:0])));
    assign w_shift = (r_state == S_SCMP) && (r_j != '0) && w_before;

    // Turn test on the two stacked vertices below the new point.
    chm_turn #(.COORD_BITS(COORD_BITS)) u_turn (
        .i_clk    (i_clk),
        .i_ox     (r_a[PT_W-1:COORD_BITS]),
        .i_oy     (r_a[COORD_BITS-1:0]),
        .i_ax     (r_b[PT_W-1:COORD_BITS]),
        .i_ay     (r_b[COORD_BITS-1:0]),
        .i_bx     (r_p[PT_W-1:COORD_BITS]),
        .i_by     (r_p[COORD_BITS-1:0]),
        .o_nonpos (w_nonpos)
    );

    assign w_chk     = (r_top >= r_floor) && (r_top >= TOP_W'(2));
    assign w_push    = ((r_state == S_HCHK) && !w_chk) || ((r_state == S_HDEC) && !w_nonpos);
    assign w_pop     = (r_state == S_HDEC) && w_nonpos;
    assign w_top_dec = r_top - TOP_W'(1);
    assign w_lower_end = !r_upper && (r_i == r_n - CNT_W'(1));
    assign w_upper_end = r_upper && (r_i == '0);
    assign w_elast   = (r_k + TOP_W'(1)) == r_top;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_acc && i_pt.last_point) begin
                    n_state = ((r_count + CNT_W'(w_store)) > CNT_W'(1)) ? S_SKEY : S_HRD;
                end
            end
            S_SKEY:  n_state = S_SKEYW;
            S_SKEYW: n_state = S_SCMP;
            S_SCMP: begin
                if (!w_shift) begin
                    n_state = ((r_i + CNT_W'(1)) < r_n) ? S_SKEY : S_HRD;
                end
            end
            S_HRD:   n_state = S_HP;
            S_HP:    n_state = S_HCHK;
            S_HCHK, S_HDEC: begin
                if (w_pop) begin
                    n_state = (w_top_dec >= TOP_W'(2)) ? S_HPOPW : S_HCHK;
                end else if (r_state == S_HCHK && w_chk) begin
                    n_state = S_HDEC;
                end else if (w_upper_end || (w_lower_end && r_n < CNT_W'(2))) begin
                    n_state = S_ERD;
                end else begin
                    n_state = S_HRD;
                end
            end
            S_HPOPW: n_state = S_HCHK;
            S_ERD:   n_state = S_ELD;
            S_ELD:   n_state = S_EOUT;
            S_EOUT: begin
                if (w_oacc) begin
                    n_state = w_elast ? S_LOAD : S_ERD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Memory addresses and write enables.
    always_comb begin
        pm_we = 1'b0;
        pm_wa = r_count[IDX_W-1:0];
        pm_wd = {i_pt.point_x, i_pt.point_y};
        pm_ra = r_i[IDX_W-1:0];
        sm_we = 1'b0;
        sm_wa = r_top[SA_W-1:0];
        sm_ra = r_k[SA_W-1:0];
        case (r_state)
            S_LOAD: pm_we = w_store;
            S_SKEYW: pm_ra = IDX_W'(r_i - CNT_W'(1));
            S_SCMP: begin
                pm_we = 1'b1;
                pm_wa = r_j;
                pm_wd = w_shift ? r_pq : r_key;
                pm_ra = IDX_W'(r_j - IDX_W'(2));
            end
            S_HCHK, S_HDEC: begin
                sm_we = w_push && (r_top < TOP_W'(STACK_DEPTH));
                sm_ra = SA_W'(r_top - TOP_W'(3));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            r_pmem[pm_wa] <= pm_wd;
        end
        r_pq <= r_pmem[pm_ra];
        if (sm_we) begin
            r_smem[sm_wa] <= r_p;
        end
        r_sq <= r_smem[sm_ra];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_top   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_store) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (r_state == S_LOAD && n_state != S_LOAD) begin
                r_top <= '0;
            end else if (w_pop) begin
                r_top <= w_top_dec;
            end else if (w_push && r_top < TOP_W'(STACK_DEPTH)) begin
                r_top <= r_top + TOP_W'(1);
            end
            if (r_state == S_ELD) begin
                r_ov <= 1'b1;
            end else if (w_oacc) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_EOUT && w_oacc && w_elast) begin
                r_count <= '0;
            end
        end
    end

    // Sequencer datapath: indices, sort key, cached stack top and output vertex.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                r_n     <= r_count + CNT_W'(w_store);
                r_i     <= (n_state == S_SKEY) ? CNT_W'(1) : '0;
                r_floor <= TOP_W'(2);
                r_upper <= 1'b0;
                r_k     <= '0;
            end
            S_SKEYW: begin
                r_key <= r_pq;
                r_j   <= r_i[IDX_W-1:0];
            end
            S_SCMP: begin
                if (w_shift) begin
                    r_j <= r_j - IDX_W'(1);
                end else begin
                    r_i <= (n_state == S_SKEY) ? r_i + CNT_W'(1) : '0;
                end
            end
            S_HP: r_p <= r_pq;
            S_HCHK, S_HDEC: begin
                if (w_pop) begin
                    r_b <= r_a;
                end else if (w_push) begin
                    r_a <= r_b;
                    r_b <= r_p;
                    if (w_lower_end) begin
                        r_upper <= 1'b1;
                        r_floor <= r_top + TOP_W'(2);
                        r_i     <= r_n - CNT_W'(2);
                    end else if (r_upper) begin
                        r_i <= r_i - CNT_W'(1);
                    end else begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
            end
            S_HPOPW: r_a <= r_sq;
            S_ELD: begin
                r_o     <= r_sq;
                r_olast <= w_elast;
            end
            S_EOUT: begin
                if (w_oacc) begin
                    r_k <= r_k + TOP_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign i_pt.ready       = (r_state == S_LOAD);
    assign o_hull.valid     = r_ov;
    assign o_hull.hull_x    = r_o[PT_W-1:COORD_BITS];
    assign o_hull.hull_y    = r_o[COORD_BITS-1:0];
    assign o_hull.hull_last = r_olast;

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(STACK_DEPTH))
        else $error("hull stack pointer beyond the stack depth");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond the store size");

    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_state == S_EOUT))
        else $error("output valid outside the emission state");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_oacc && o_hull.hull_last) |=> (r_state == S_LOAD && r_count == '0))
        else $error("set not cleared after its final vertex");
endmodule

[hdl/chm_turn.sv]
// Exact cross product sign unit with registered products for the hull walk.
module chm_turn #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic signed [COORD_BITS-1:0] i_ox,
    input  logic signed [COORD_BITS-1:0] i_oy,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    output logic                         o_nonpos
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] w_dax, w_day, w_dbx, w_dby;
    logic signed [PW-1:0] r_p1, r_p2;

    // Differences relative to the origin point, one bit wider than a coordinate.
    assign w_dax = DW'(i_ax) - DW'(i_ox);
    assign w_day = DW'(i_ay) - DW'(i_oy);
    assign w_dbx = DW'(i_bx) - DW'(i_ox);
    assign w_dby = DW'(i_by) - DW'(i_oy);

    // Both products are registered before the comparison.
    always_ff @(posedge i_clk) begin
        r_p1 <= PW'(w_dax) * PW'(w_dby);
        r_p2 <= PW'(w_day) * PW'(w_dbx);
    end

    // The turn is zero or clockwise when the first product does not exceed the second.
    assign o_nonpos = (r_p1 <= r_p2);
endmodule
